/* rtl/core/csia_pkg.sv */
// shared types and constants for the checked signed integer alu
package csia_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned NumCells = DataW;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_PLUS = 3'd4,
    OP_NEG = 3'd5,
    OP_ABS = 3'd6,
    OP_CMP = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_OVF = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  // what a cell does to the beat passing through it
  typedef enum logic [1:0] {
    K_PASS = 2'd0,
    K_MUL = 2'd1,
    K_DIV = 2'd2
  } kind_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic wide_mode;
    logic signed [DataW-1:0] left_operand;
    logic signed [DataW-1:0] right_operand;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] result_value;
    logic [1:0] status;
  } out_t;

  // per-cell state: acc is the product high half or the partial remainder,
  // a the multiplicand or divisor, b the multiplier/product low or quotient
  typedef struct packed {
    kind_e kind;
    logic wide;
    logic neg;
    status_e st;
    logic [DataW-1:0] acc;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } stage_t;

endpackage

/* rtl/core/csia_front.sv */
// operand decode, and the operations that need no cell steps, ahead of the cell row
module csia_front (
  input  csia_pkg::in_t    beat_i,
  output csia_pkg::stage_t stage_o
);

  logic [63:0] a, b, mag_a, mag_b, t_add, t_sub, res;
  logic sa, sb, a_min, ovf_add, ovf_sub;

  always_comb begin
    a = beat_i.wide_mode ? beat_i.left_operand
                         : {{32{beat_i.left_operand[31]}}, beat_i.left_operand[31:0]};
    b = beat_i.wide_mode ? beat_i.right_operand
                         : {{32{beat_i.right_operand[31]}}, beat_i.right_operand[31:0]};
    sa = a[63];
    sb = b[63];
    mag_a = sa ? (64'd0 - a) : a;
    mag_b = sb ? (64'd0 - b) : b;
    a_min = beat_i.wide_mode ? (a == 64'h8000_0000_0000_0000)
                             : (a == 64'hFFFF_FFFF_8000_0000);
    t_add = a + b;
    t_sub = a - b;
    ovf_add = beat_i.wide_mode ? ((a[63] ^ t_add[63]) & (b[63] ^ t_add[63]))
                               : (t_add != {{32{t_add[31]}}, t_add[31:0]});
    ovf_sub = beat_i.wide_mode ? ((a[63] ^ b[63]) & (a[63] ^ t_sub[63]))
                               : (t_sub != {{32{t_sub[31]}}, t_sub[31:0]});

    stage_o.kind = csia_pkg::K_PASS;
    stage_o.wide = beat_i.wide_mode;
    stage_o.neg = sa ^ sb;
    stage_o.st = csia_pkg::ST_OK;
    stage_o.acc = '0;
    stage_o.a = '0;
    res = '0;

    unique case (csia_pkg::op_e'(beat_i.req_type))
      csia_pkg::OP_ADD: begin
        res = t_add;
        if (ovf_add) stage_o.st = csia_pkg::ST_OVF;
      end
      csia_pkg::OP_SUB: begin
        res = t_sub;
        if (ovf_sub) stage_o.st = csia_pkg::ST_OVF;
      end
      csia_pkg::OP_MUL: begin
        stage_o.kind = csia_pkg::K_MUL;
        stage_o.a = mag_a;
        res = mag_b;
      end
      csia_pkg::OP_DIV: begin
        if (b == 64'd0) begin
          stage_o.st = csia_pkg::ST_DIVZ;
        end else begin
          stage_o.kind = csia_pkg::K_DIV;
          stage_o.a = mag_b;
          res = mag_a;
        end
      end
      csia_pkg::OP_PLUS: res = a;
      csia_pkg::OP_NEG: begin
        res = 64'd0 - a;
        if (a_min) stage_o.st = csia_pkg::ST_OVF;
      end
      csia_pkg::OP_ABS: begin
        res = mag_a;
        if (a_min) stage_o.st = csia_pkg::ST_OVF;
      end
      csia_pkg::OP_CMP: begin
        if ($signed(a) < $signed(b)) res = 64'hFFFF_FFFF_FFFF_FFFF;
        else if (a != b) res = 64'd1;
        else res = 64'd0;
      end
      default: res = '0;
    endcase

    if (stage_o.st != csia_pkg::ST_OK) res = '0;
    stage_o.b = res;
  end

endmodule

/* rtl/core/csia_cell.sv */
// one step cell: a shift-add multiply bit or a restoring divide bit
module csia_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  csia_pkg::stage_t stage_i,
  output logic             valid_o,
  output csia_pkg::stage_t stage_o
);

  logic valid_q;
  csia_pkg::stage_t stage_q, stage_d;
  logic [64:0] sum, trial, diff;
  logic ge;

  always_comb begin
    stage_d = stage_i;
    sum = {1'b0, stage_i.acc} + (stage_i.b[0] ? {1'b0, stage_i.a} : 65'd0);
    trial = {stage_i.acc, stage_i.b[63]};
    diff = trial - {1'b0, stage_i.a};
    ge = trial >= {1'b0, stage_i.a};
    case (stage_i.kind)
      csia_pkg::K_MUL: begin
        stage_d.acc = sum[64:1];
        stage_d.b = {sum[0], stage_i.b[63:1]};
      end
      csia_pkg::K_DIV: begin
        stage_d.acc = ge ? diff[63:0] : trial[63:0];
        stage_d.b = {stage_i.b[62:0], ge};
      end
      default: stage_d = stage_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

/* rtl/core/csia_finish.sv */
// range check and sign restore after the last cell
module csia_finish (
  input  csia_pkg::stage_t stage_i,
  output csia_pkg::out_t   beat_o
);

  logic [63:0] mag, lim;
  logic ovf;

  always_comb begin
    mag = stage_i.b;
    if (stage_i.wide) lim = stage_i.neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    else lim = stage_i.neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    ovf = (mag > lim) || ((stage_i.kind == csia_pkg::K_MUL) && (stage_i.acc != 64'd0));
    beat_o.status = stage_i.st;
    beat_o.result_value = stage_i.b;
    if (stage_i.kind != csia_pkg::K_PASS) begin
      if (ovf) begin
        beat_o.status = csia_pkg::ST_OVF;
        beat_o.result_value = '0;
      end else begin
        beat_o.result_value = stage_i.neg ? (64'd0 - mag) : mag;
      end
    end
  end

endmodule

/* rtl/core/checked_signed_integer_alu_unit.sv */
// top level of the checked signed integer alu: front, cell row, finish, output register
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_ready_o   | in_beat_i  (csia_pkg::in_t)
//   out     | output    | out_valid_o / out_ready_i | out_beat_o (csia_pkg::out_t)
//
// one beat per cycle is accepted while the row is not stalled; each beat passes the cell row, then the output register
// the row has 64 cells, one product or quotient bit per cell
// the whole row advances together; it holds only while the output beat waits
// reset clears the valid bits of the row and the output register
module checked_signed_integer_alu_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  csia_pkg::in_t  in_beat_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output csia_pkg::out_t out_beat_o
);

  localparam int unsigned N = csia_pkg::NumCells;

  logic en;
  logic [N:0] valid_c;
  csia_pkg::stage_t stage_c [N+1];
  csia_pkg::out_t fin_beat, out_q;
  logic out_valid_q;

  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign valid_c[0] = in_valid_i;

  csia_front u_front (
    .beat_i (in_beat_i),
    .stage_o(stage_c[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    csia_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(valid_c[i]),
      .stage_i(stage_c[i]),
      .valid_o(valid_c[i+1]),
      .stage_o(stage_c[i+1])
    );
  end

  csia_finish u_finish (
    .stage_i(stage_c[N]),
    .beat_o (fin_beat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_c[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= fin_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o = out_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != csia_pkg::ST_OK) |-> out_q.result_value == '0)
    else $error("error beat with nonzero result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.status != 2'd3)
    else $error("bad status code");

  a_last_cell_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && valid_c[N] |=> out_valid_q)
    else $error("beat lost after last cell");

  // the row registers only; the input valid may rise during a stall
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_c[N:1]))
    else $error("row moved while stalled");

endmodule
